// ----- sv/trss_pkg.sv -----
// Shared constants, types and helpers for the tensor sum-of-squares reduction core.
package trss_pkg;

  // Tensor geometry and accumulator store.
  localparam int MAX_RANK    = 4;
  localparam int RANK_IDX_W  = $clog2(MAX_RANK);
  localparam int STORE_DEPTH = 4096;
  localparam int SLOT_W      = $clog2(STORE_DEPTH);
  localparam int COORD_W     = 12;
  localparam int EXT_W       = 13;
  localparam int EXTENT_MAX  = 4096;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;
  localparam int RANK_W     = 3;

  // Floating-point datapath.
  localparam int FLOAT_W   = 32;
  localparam int FP_STAGES = 4;
  localparam logic [FLOAT_W-1:0] FP_POS_INF   = 32'h7F80_0000;
  localparam logic [FLOAT_W-1:0] FP_QUIET_BIT = 32'h0040_0000;
  localparam logic [FLOAT_W-1:0] FP_POS_ZERO  = 32'h0000_0000;

  // Result queue and output-count settling time after a configuration write.
  localparam int OUT_DEPTH = 4;
  localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int SETTLE    = MAX_RANK - 1;
  localparam int SETTLE_W  = $clog2(SETTLE + 1);

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RANK  = 3'd0,
    CFG_SIZE0 = 3'd1,
    CFG_SIZE1 = 3'd2,
    CFG_SIZE2 = 3'd3,
    CFG_SIZE3 = 3'd4,
    CFG_MASK  = 3'd5
  } cfg_reg_t;

  // Operation carried by an input transaction.
  typedef enum logic {
    OP_ACCUM = 1'b0,
    OP_READ  = 1'b1
  } op_t;

  // Entry held by one stage of the accumulate pipeline.
  typedef struct packed {
    logic              valid;
    logic [SLOT_W-1:0] slot;
  } slot_lock_t;

  // Write-back request into the accumulator store.
  typedef struct packed {
    logic               en;
    logic [SLOT_W-1:0]  addr;
    logic [FLOAT_W-1:0] data;
  } store_wr_t;

  // Product of two extents, saturated at the largest extent.
  function automatic logic [EXT_W-1:0] sat_mul(input logic [EXT_W-1:0] a,
                                               input logic [EXT_W-1:0] b);
    logic [2*EXT_W-1:0] p;
    p = a * b;
    if (p > (2*EXT_W)'(EXTENT_MAX)) begin
      return EXT_W'(EXTENT_MAX);
    end
    return p[EXT_W-1:0];
  endfunction

endpackage

// ----- sv/trss_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module trss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; data is registered and appears in the cycle after the address.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/trss_fpu.sv -----
// Four-stage single-precision square and accumulate pipeline feeding the store write port.
module trss_fpu import trss_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_first,
  input  logic [SLOT_W-1:0]             in_slot,
  input  logic [FLOAT_W-1:0]            in_x,
  input  logic [FLOAT_W-1:0]            acc_data,
  output store_wr_t                     wr,
  output slot_lock_t [FP_STAGES-1:0]    lock
);

  // Stage 1: captured element; the store read is in flight.
  logic               p1_valid;
  logic               p1_first;
  logic [SLOT_W-1:0]  p1_slot;
  logic [FLOAT_W-1:0] p1_x;
  logic [23:0]        p1_man;

  // Stage 2: mantissa product and the accumulator read back.
  logic               p2_valid;
  logic               p2_first;
  logic [SLOT_W-1:0]  p2_slot;
  logic [FLOAT_W-1:0] p2_x;
  logic [47:0]        p2_prod;
  logic [FLOAT_W-1:0] p2_acc;

  // Stage 3: rounded square.
  logic               p3_valid;
  logic               p3_first;
  logic [SLOT_W-1:0]  p3_slot;
  logic [FLOAT_W-1:0] p3_sq;
  logic [FLOAT_W-1:0] p3_acc;

  // Stage 4: aligned addends.
  logic               p4_valid;
  logic               p4_first;
  logic [SLOT_W-1:0]  p4_slot;
  logic [FLOAT_W-1:0] p4_sq;
  logic               p4_spec;
  logic [FLOAT_W-1:0] p4_specval;
  logic [26:0]        p4_ma;
  logic [26:0]        p4_mb;
  logic [7:0]         p4_ex;

  // Square rounding signals.
  logic [7:0]         sq_xe;
  logic [9:0]         sq_eb;
  logic [47:0]        sq_n;
  logic [9:0]         sq_dsh;
  logic [4:0]         sq_dc;
  logic [95:0]        sq_sh;
  logic [47:0]        sq_r;
  logic               sq_ext;
  logic [7:0]         sq_ef;
  logic               sq_inc;
  logic [FLOAT_W-1:0] sq_rnd;
  logic [FLOAT_W-1:0] sq_val;

  // Alignment signals.
  logic               al_anan, al_ainf, al_bnan, al_binf;
  logic               al_spec;
  logic [FLOAT_W-1:0] al_specval;
  logic               al_swap;
  logic [FLOAT_W-1:0] al_big, al_sml;
  logic [7:0]         al_ebig, al_esml, al_d;
  logic [4:0]         al_dc;
  logic [23:0]        al_mbig, al_msml;
  logic [53:0]        al_sh;
  logic [26:0]        al_mb;

  // Add and round signals.
  logic [27:0]        ad_sum;
  logic [26:0]        ad_m;
  logic [8:0]         ad_ex;
  logic [8:0]         ad_biased;
  logic               ad_inc;
  logic [FLOAT_W-1:0] ad_res;

  assign p1_man = {1'b1, p1_x[22:0]};

  // Pipeline valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
      p3_valid <= 1'b0;
      p4_valid <= 1'b0;
    end else begin
      p1_valid <= in_valid;
      p2_valid <= p1_valid;
      p3_valid <= p2_valid;
      p4_valid <= p3_valid;
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk) begin
    p1_first   <= in_first;
    p1_slot    <= in_slot;
    p1_x       <= in_x;
    p2_first   <= p1_first;
    p2_slot    <= p1_slot;
    p2_x       <= p1_x;
    p2_prod    <= p1_man * p1_man;
    p2_acc     <= acc_data;
    p3_first   <= p2_first;
    p3_slot    <= p2_slot;
    p3_sq      <= sq_val;
    p3_acc     <= p2_acc;
    p4_first   <= p3_first;
    p4_slot    <= p3_slot;
    p4_sq      <= p3_sq;
    p4_spec    <= al_spec;
    p4_specval <= al_specval;
    p4_ma      <= {al_mbig, 3'b000};
    p4_mb      <= al_mb;
    p4_ex      <= al_ebig;
  end

  // Normalize and round the square; subnormal inputs square to zero.
  always_comb begin
    sq_xe  = p2_x[30:23];
    sq_eb  = {1'b0, sq_xe, 1'b0} + {9'b0, p2_prod[47]};
    sq_n   = p2_prod[47] ? p2_prod : {p2_prod[46:0], 1'b0};
    sq_dsh = 10'd128 - sq_eb;
    sq_dc  = (sq_dsh > 10'd25) ? 5'd25 : sq_dsh[4:0];
    sq_sh  = {sq_n, 48'b0} >> sq_dc;
    if (sq_eb >= 10'd128) begin
      sq_ef  = 8'(sq_eb - 10'd127);
      sq_r   = sq_n;
      sq_ext = 1'b0;
    end else begin
      sq_ef  = 8'd0;
      sq_r   = sq_sh[95:48];
      sq_ext = |sq_sh[47:0];
    end
    sq_inc = sq_r[23] & ((|sq_r[22:0]) | sq_ext | sq_r[24]);
    sq_rnd = {1'b0, sq_ef, sq_r[46:24]} + {31'b0, sq_inc};
    if (sq_xe == 8'd0) begin
      sq_val = FP_POS_ZERO;
    end else if (sq_xe == 8'hFF) begin
      sq_val = (|p2_x[22:0]) ? (p2_x | FP_QUIET_BIT) : FP_POS_INF;
    end else if (sq_eb >= 10'd382) begin
      sq_val = FP_POS_INF;
    end else begin
      sq_val = sq_rnd;
    end
  end

  // Special operands and exponent alignment of the smaller addend.
  always_comb begin
    al_anan = (&p3_acc[30:23]) & (|p3_acc[22:0]);
    al_ainf = (&p3_acc[30:23]) & ~(|p3_acc[22:0]);
    al_bnan = (&p3_sq[30:23]) & (|p3_sq[22:0]);
    al_binf = (&p3_sq[30:23]) & ~(|p3_sq[22:0]);
    al_spec = al_anan | al_ainf | al_bnan | al_binf;
    if (al_anan) begin
      al_specval = p3_acc | FP_QUIET_BIT;
    end else if (al_bnan) begin
      al_specval = p3_sq | FP_QUIET_BIT;
    end else begin
      al_specval = FP_POS_INF;
    end
    al_swap = p3_sq[30:0] > p3_acc[30:0];
    al_big  = al_swap ? p3_sq : p3_acc;
    al_sml  = al_swap ? p3_acc : p3_sq;
    al_ebig = (al_big[30:23] == 8'd0) ? 8'd1 : al_big[30:23];
    al_esml = (al_sml[30:23] == 8'd0) ? 8'd1 : al_sml[30:23];
    al_mbig = {|al_big[30:23], al_big[22:0]};
    al_msml = {|al_sml[30:23], al_sml[22:0]};
    al_d    = al_ebig - al_esml;
    al_dc   = (al_d > 8'd27) ? 5'd27 : al_d[4:0];
    al_sh   = {al_msml, 30'b0} >> al_dc;
    al_mb   = {al_sh[53:28], al_sh[27] | (|al_sh[26:0])};
  end

  // Add two nonnegative values, renormalize by at most one place and round.
  always_comb begin
    ad_sum = {1'b0, p4_ma} + {1'b0, p4_mb};
    if (ad_sum[27]) begin
      ad_m = {ad_sum[27:2], ad_sum[1] | ad_sum[0]};
    end else begin
      ad_m = ad_sum[26:0];
    end
    ad_ex     = {1'b0, p4_ex} + {8'b0, ad_sum[27]};
    ad_biased = ad_ex - 9'd1;
    ad_inc    = ad_m[2] & ((|ad_m[1:0]) | ad_m[3]);
    ad_res    = {1'b0, ad_biased[7:0], 23'b0} + {8'b0, ad_m[26:3]} + {31'b0, ad_inc};
  end

  // Write-back request.
  always_comb begin
    wr.en   = p4_valid;
    wr.addr = p4_slot;
    if (p4_first) begin
      wr.data = p4_sq;
    end else if (p4_spec) begin
      wr.data = p4_specval;
    end else if (ad_ex >= 9'd255) begin
      wr.data = FP_POS_INF;
    end else begin
      wr.data = ad_res;
    end
  end

  // Entries held by each stage, for the read-after-write interlock.
  always_comb begin
    lock[0].valid = p1_valid;
    lock[0].slot  = p1_slot;
    lock[1].valid = p2_valid;
    lock[1].slot  = p2_slot;
    lock[2].valid = p3_valid;
    lock[2].slot  = p3_slot;
    lock[3].valid = p4_valid;
    lock[3].slot  = p4_slot;
  end

endmodule

// ----- sv/tensor_reduce_sum_square_core.sv -----
// Top level of the tensor sum-of-squares reduction core.
//
//   Channel   Direction  Signals                       Content
//   s_axis    in         tvalid tready tdata tuser     element or read request
//   m_axis    out        tvalid tready tdata tuser     reduced result and index flag
//   cfg       in         cfg_we cfg_index cfg_data     register write, no read-back
//
// One transaction is taken per cycle while s_axis_tready is high. An accumulate or read
// that targets an entry still inside the four-stage float pipeline waits until that
// entry is written back, so repeated hits on one entry are paced by the store's
// read-modify-write loop. A configuration write holds s_axis_tready low while the
// output count settles. Reset is synchronous and clears control state only; the store
// is not cleared. Results wait in a four-entry queue, and read requests are held back
// when it has no room; accumulates never wait on m_axis.
module tensor_reduce_sum_square_core import trss_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [47:0]           s_axis_tdata,  // element_bits[31:0], read_index[43:32]
  input  logic [0:0]            s_axis_tuser,  // opcode[0]
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [31:0]           m_axis_tdata,  // result_bits[31:0]
  output logic [0:0]            m_axis_tuser,  // index_error[0]
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers.
  logic [RANK_W-1:0]   rank_reg;
  logic [EXT_W-1:0]    size_reg [MAX_RANK];
  logic [MAX_RANK-1:0] mask_reg;
  logic                cfg_hit;

  // Derived geometry.
  logic [RANK_W-1:0]   rank_eff;
  logic [EXT_W-1:0]    ext [MAX_RANK];
  logic [EXT_W-1:0]    kept_ext [MAX_RANK];
  logic [MAX_RANK-1:0] red;
  logic [EXT_W-1:0]    oc [MAX_RANK-1];
  logic [EXT_W-1:0]    out_count;
  logic [SETTLE_W-1:0] settle;

  // Row-major position counters.
  logic [COORD_W-1:0]  coord [MAX_RANK];
  logic [SLOT_W-1:0]   base [MAX_RANK];
  logic [SLOT_W-1:0]   addr;
  logic [COORD_W-1:0]  coord_next [MAX_RANK];
  logic [SLOT_W-1:0]   base_next [MAX_RANK];
  logic [SLOT_W-1:0]   addr_next;
  logic                first;

  // Input side.
  logic                acc_op;
  logic [SLOT_W-1:0]   req_slot;
  logic [11:0]         read_index;
  logic                hazard;
  logic                room;
  logic                in_accept;
  logic                idx_err;

  // Store and pipeline.
  store_wr_t                  store_wr;
  slot_lock_t [FP_STAGES-1:0] lock;
  logic [FLOAT_W-1:0]         rdata;
  logic                       p1_rd;
  logic                       p1_err;

  // Result queue.
  logic [FLOAT_W:0]     fifo_mem [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] head;
  logic [OUT_PTR_W-1:0] tail;
  logic [OUT_PTR_W:0]   cnt;
  logic                 push;
  logic                 pop;

  // Configuration writes; any listed register restarts the tensor.
  always_ff @(posedge clk) begin
    if (rst) begin
      rank_reg <= RANK_W'(MAX_RANK);
      mask_reg <= '0;
      for (int k = 0; k < MAX_RANK; k++) begin
        size_reg[k] <= EXT_W'(1);
      end
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_RANK:  rank_reg    <= cfg_data[RANK_W-1:0];
        CFG_SIZE0: size_reg[0] <= cfg_data[EXT_W-1:0];
        CFG_SIZE1: size_reg[1] <= cfg_data[EXT_W-1:0];
        CFG_SIZE2: size_reg[2] <= cfg_data[EXT_W-1:0];
        CFG_SIZE3: size_reg[3] <= cfg_data[EXT_W-1:0];
        CFG_MASK:  mask_reg    <= cfg_data[MAX_RANK-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_reg_t'(cfg_index))
      CFG_RANK, CFG_SIZE0, CFG_SIZE1, CFG_SIZE2, CFG_SIZE3, CFG_MASK: cfg_hit = cfg_we;
      default: cfg_hit = 1'b0;
    endcase
  end

  // Clamp rank and extents; axes past the rank act as kept axes of extent one.
  always_comb begin
    if (rank_reg == '0) begin
      rank_eff = RANK_W'(1);
    end else if (rank_reg > RANK_W'(MAX_RANK)) begin
      rank_eff = RANK_W'(MAX_RANK);
    end else begin
      rank_eff = rank_reg;
    end
    for (int k = 0; k < MAX_RANK; k++) begin
      if (k >= int'(rank_eff)) begin
        ext[k] = EXT_W'(1);
      end else if (size_reg[k] == '0) begin
        ext[k] = EXT_W'(1);
      end else if (size_reg[k] > EXT_W'(EXTENT_MAX)) begin
        ext[k] = EXT_W'(EXTENT_MAX);
      end else begin
        ext[k] = size_reg[k];
      end
      red[k]      = mask_reg[k] && (k < int'(rank_eff));
      kept_ext[k] = red[k] ? EXT_W'(1) : ext[k];
    end
  end

  // Output count as a chain of registered saturating products.
  always_ff @(posedge clk) begin
    oc[0] <= sat_mul(kept_ext[0], kept_ext[1]);
    for (int i = 1; i < MAX_RANK - 1; i++) begin
      oc[i] <= sat_mul(oc[i-1], kept_ext[i+1]);
    end
  end

  assign out_count = oc[MAX_RANK-2];

  // Hold off input until the output count reflects the latest configuration.
  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      settle <= SETTLE_W'(SETTLE);
    end else if (settle != '0) begin
      settle <= settle - SETTLE_W'(1);
    end
  end

  // Next position: innermost axis that does not wrap advances, inner axes clear.
  always_comb begin
    logic                  found;
    logic [RANK_IDX_W-1:0] kpos;
    found     = 1'b0;
    kpos      = '0;
    addr_next = '0;
    for (int k = 0; k < MAX_RANK; k++) begin
      coord_next[k] = coord[k];
      base_next[k]  = '0;
    end
    for (int k = MAX_RANK - 1; k >= 0; k--) begin
      if (!found) begin
        if ((EXT_W'(coord[k]) + EXT_W'(1)) >= ext[k]) begin
          coord_next[k] = '0;
        end else begin
          found         = 1'b1;
          kpos          = RANK_IDX_W'(k);
          coord_next[k] = coord[k] + COORD_W'(1);
          addr_next     = red[k] ? base[k] : addr + SLOT_W'(1);
        end
      end
    end
    if (found) begin
      for (int k = 0; k < MAX_RANK; k++) begin
        base_next[k] = (k >= int'(kpos)) ? addr_next : base[k];
      end
    end
  end

  // An element overwrites its entry when every reduced coordinate is zero.
  always_comb begin
    first = 1'b1;
    for (int k = 0; k < MAX_RANK; k++) begin
      if (red[k] && coord[k] != '0) begin
        first = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      addr <= '0;
      for (int k = 0; k < MAX_RANK; k++) begin
        coord[k] <= '0;
        base[k]  <= '0;
      end
    end else if (in_accept && acc_op) begin
      addr <= addr_next;
      for (int k = 0; k < MAX_RANK; k++) begin
        coord[k] <= coord_next[k];
        base[k]  <= base_next[k];
      end
    end
  end

  // Acceptance: interlock on entries still in the float pipeline.
  assign acc_op     = (op_t'(s_axis_tuser[0]) == OP_ACCUM);
  assign read_index = s_axis_tdata[43:32];
  assign req_slot   = acc_op ? addr : read_index[SLOT_W-1:0];
  assign idx_err    = {1'b0, read_index} >= out_count;

  always_comb begin
    hazard = 1'b0;
    for (int i = 0; i < FP_STAGES; i++) begin
      if (lock[i].valid && lock[i].slot == req_slot) begin
        hazard = 1'b1;
      end
    end
  end

  assign room          = (cnt + (OUT_PTR_W+1)'(p1_rd)) < (OUT_PTR_W+1)'(OUT_DEPTH);
  assign s_axis_tready = (settle == '0) && !hazard && (acc_op || room);
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  // Accumulator store.
  trss_ram #(
    .WIDTH (FLOAT_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (store_wr.en),
    .waddr (store_wr.addr),
    .wdata (store_wr.data),
    .re    (in_accept),
    .raddr (req_slot),
    .rdata (rdata)
  );

  // Square and accumulate pipeline.
  trss_fpu u_fpu (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_accept && acc_op),
    .in_first (first),
    .in_slot  (addr),
    .in_x     (s_axis_tdata[31:0]),
    .acc_data (rdata),
    .wr       (store_wr),
    .lock     (lock)
  );

  // Read requests are registered in p1_rd and meet the store data in the next cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_rd <= 1'b0;
    end else begin
      p1_rd <= in_accept && !acc_op;
    end
  end

  always_ff @(posedge clk) begin
    p1_err <= idx_err;
  end

  // Result queue.
  assign push = p1_rd;
  assign pop  = m_axis_tvalid && m_axis_tready;
  assign tail = OUT_PTR_W'(head + cnt[OUT_PTR_W-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      head <= '0;
    end else begin
      cnt <= cnt + (OUT_PTR_W+1)'(push) - (OUT_PTR_W+1)'(pop);
      if (pop) begin
        head <= head + OUT_PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[tail] <= {p1_err, p1_err ? FP_POS_ZERO : rdata};
    end
  end

  assign m_axis_tvalid = (cnt != '0);
  assign m_axis_tdata  = fifo_mem[head][FLOAT_W-1:0];
  assign m_axis_tuser  = fifo_mem[head][FLOAT_W];

  // A store read never coincides with a write-back to the same entry.
  a_no_rw_collision: assert property (@(posedge clk) disable iff (rst)
    in_accept |-> !(store_wr.en && store_wr.addr == req_slot))
    else $error("store read collides with write-back to the same entry");

  // The result queue never takes an entry it has no room for.
  a_queue_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (cnt < (OUT_PTR_W+1)'(OUT_DEPTH) || pop))
    else $error("result queue overflow");

  // Input is held off right after a configuration write.
  a_cfg_hold: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> !s_axis_tready)
    else $error("input accepted before output count settled");

  // Each accepted read yields a queued result in the following cycle.
  a_read_pushes: assert property (@(posedge clk) disable iff (rst)
    (in_accept && !acc_op) |=> push)
    else $error("read request lost");

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for the tensor sum-of-squares reduction core.
module testbench;
  import trss_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Expected result of one read transaction.
  typedef struct {
    logic [31:0] sum_bits;
    logic        idx_err;
  } sum_read_t;

  // Scoreboard: mirrors the core's accumulator store and coordinate counters.
  class sum_square_scoreboard;
    logic [31:0] acc_store [STORE_DEPTH];
    bit          touched   [STORE_DEPTH];
    int unsigned coord     [MAX_RANK];
    int unsigned rank_reg;
    int unsigned extent_reg [4];
    int unsigned mask_reg;
    sum_read_t   pending_reads [$];
    int          errors;

    function new();
      rank_reg = 4;
      foreach (extent_reg[k]) extent_reg[k] = 1;
      mask_reg = 0;
      foreach (coord[k]) coord[k] = 0;
      foreach (touched[k]) touched[k] = 0;
      errors = 0;
    endfunction

    function int unsigned used_rank();
      if (rank_reg < 1) return 1;
      if (rank_reg > MAX_RANK) return MAX_RANK;
      return rank_reg;
    endfunction

    function longint unsigned extent(int k);
      if (extent_reg[k] < 1) return 1;
      if (extent_reg[k] > EXTENT_MAX) return EXTENT_MAX;
      return extent_reg[k];
    endfunction

    function longint unsigned out_count();
      longint unsigned n;
      n = 1;
      for (int k = 0; k < used_rank(); k++)
        if (!mask_reg[k]) n = n * extent(k);
      return n;
    endfunction

    function longint unsigned tensor_size();
      longint unsigned n;
      n = 1;
      for (int k = 0; k < used_rank(); k++) n = n * extent(k);
      return n;
    endfunction

    // A register write also restarts the tensor.
    function void set_reg(cfg_reg_t idx, int unsigned val);
      case (idx)
        CFG_RANK:  rank_reg = val & 7;
        CFG_SIZE0: extent_reg[0] = val & 16'h1FFF;
        CFG_SIZE1: extent_reg[1] = val & 16'h1FFF;
        CFG_SIZE2: extent_reg[2] = val & 16'h1FFF;
        CFG_SIZE3: extent_reg[3] = val & 16'h1FFF;
        CFG_MASK:  mask_reg = val & 15;
        default: ;
      endcase
      foreach (coord[k]) coord[k] = 0;
    endfunction

    // Round m * 2^e (m nonzero, positive) to single precision, nearest even.
    function logic [31:0] round_pack(int e, logic [127:0] m);
      int p, q, sh, bexp;
      logic [127:0] keep, rem, half;
      p = 0;
      for (int i = 0; i < 128; i++) if (m[i]) p = i;
      q = e + p - 23;
      if (q < -149) q = -149;
      sh = q - e;
      if (sh > 120) return 32'h0;
      if (sh > 0) begin
        keep = m >> sh;
        rem  = m & ((128'd1 << sh) - 1);
        half = 128'd1 << (sh - 1);
        if (rem > half || (rem == half && keep[0])) keep = keep + 1;
      end else begin
        keep = m << (-sh);
      end
      if (keep[24]) begin
        keep = keep >> 1;
        q = q + 1;
      end
      if (keep < 128'h80_0000) return keep[31:0];
      bexp = q + 150;
      if (bexp >= 255) return 32'h7F80_0000;
      return {1'b0, 8'(bexp), keep[22:0]};
    endfunction

    function void split(logic [31:0] f, output int e, output logic [23:0] m);
      if (f[30:23] == 8'd0) begin
        m = {1'b0, f[22:0]};
        e = -149;
      end else begin
        m = {1'b1, f[22:0]};
        e = int'(f[30:23]) - 150;
      end
    endfunction

    // A NaN squares to itself made quiet, sign kept.
    function logic [31:0] square(logic [31:0] x);
      int e;
      logic [23:0] m;
      logic [127:0] p;
      if (x[30:23] == 8'hFF)
        return (x[22:0] != 0) ? (x | 32'h0040_0000) : 32'h7F80_0000;
      split(x, e, m);
      if (m == 0) return 32'h0;
      p = 128'(m) * 128'(m);
      return round_pack(2 * e, p);
    endfunction

    // Sum of two non-negative values; no cancellation can occur.
    // A NaN accumulator wins over a NaN square.
    function logic [31:0] add_pos(logic [31:0] a, logic [31:0] b);
      int ea, eb, et;
      logic [23:0] ma, mb, mt;
      logic [127:0] s;
      if (a[30:23] == 8'hFF && a[22:0] != 0) return a | 32'h0040_0000;
      if (b[30:23] == 8'hFF && b[22:0] != 0) return b | 32'h0040_0000;
      if (a[30:23] == 8'hFF || b[30:23] == 8'hFF) return 32'h7F80_0000;
      split(a, ea, ma);
      split(b, eb, mb);
      if (ma == 0) return b;
      if (mb == 0) return a;
      if (ea - eb > 40) return a;
      if (eb - ea > 40) return b;
      if (ea < eb) begin
        et = ea; ea = eb; eb = et;
        mt = ma; ma = mb; mb = mt;
      end
      s = (128'(ma) << (ea - eb)) + 128'(mb);
      return round_pack(eb, s);
    endfunction

    function bit readable(int unsigned idx);
      return idx >= out_count() || touched[idx];
    endfunction

    function int pending();
      return pending_reads.size();
    endfunction

    // Note one accepted input transaction and predict its result, if any.
    function void note_input(op_t op, logic [31:0] elem, logic [11:0] idx);
      sum_read_t r;
      longint unsigned addr;
      bit first;
      int k;
      logic [11:0] slot;
      if (op == OP_READ) begin
        if (idx < out_count()) begin
          r.sum_bits = acc_store[idx];
          r.idx_err  = 1'b0;
        end else begin
          r.sum_bits = 32'h0;
          r.idx_err  = 1'b1;
        end
        pending_reads.push_back(r);
        return;
      end
      addr  = 0;
      first = 1;
      for (k = 0; k < used_rank(); k++) begin
        if (mask_reg[k]) begin
          if (coord[k] != 0) first = 0;
        end else begin
          addr = addr * extent(k) + coord[k];
        end
      end
      slot = addr[11:0];
      if (first) acc_store[slot] = square(elem);
      else acc_store[slot] = add_pos(acc_store[slot], square(elem));
      touched[slot] = 1;
      // Row-major advance, innermost axis first.
      k = used_rank();
      while (k > 0) begin
        k--;
        coord[k]++;
        if (coord[k] < extent(k)) break;
        coord[k] = 0;
      end
    endfunction

    task report(string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    // Compare one accepted result with the oldest expectation.
    task check_result(logic [31:0] bits, logic err);
      sum_read_t r;
      if (pending_reads.size() == 0) begin
        report($sformatf("unexpected result %h err %b", bits, err));
        return;
      end
      r = pending_reads.pop_front();
      if (bits !== r.sum_bits)
        report($sformatf("result_bits %h, expected %h", bits, r.sum_bits));
      if (err !== r.idx_err)
        report($sformatf("index_error %b, expected %b", err, r.idx_err));
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;   // element_bits[31:0], read_index[43:32]
  logic [0:0]  s_axis_tuser;   // opcode[0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // result_bits[31:0]
  logic [0:0]  m_axis_tuser;   // index_error[0]
  logic        cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  sum_square_scoreboard sb;
  int tx_idle_pct;
  int rx_idle_pct;
  int rx_hold;
  int sent;

  tensor_reduce_sum_square_core u_top (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Overall time limit.
  initial begin
    #4_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Receiver: random back-pressure, with a long hold-off while rx_hold is set.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold > 0) begin
        rx_hold--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata, m_axis_tuser[0]);
  end

  // Offer one input transaction and wait until it is accepted.
  task send(op_t op, logic [31:0] elem, logic [11:0] idx);
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, idx, elem};
    s_axis_tuser  <= op;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_input(op, elem, idx);
    sent++;
  endtask

  // Stop offering and let every expected result arrive, then the pipeline empty.
  task drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() > 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task write_reg(cfg_reg_t idx, int unsigned val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(val);
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  task set_shape(int unsigned rank, int unsigned e0, int unsigned e1, int unsigned e2,
                 int unsigned e3, int unsigned mask);
    write_reg(CFG_RANK, rank);
    write_reg(CFG_SIZE0, e0);
    write_reg(CFG_SIZE1, e1);
    write_reg(CFG_SIZE2, e2);
    write_reg(CFG_SIZE3, e3);
    write_reg(CFG_MASK, mask);
  endtask

  // Random element, never a NaN; mostly moderate magnitudes.
  function logic [31:0] rand_elem();
    logic [31:0] v;
    if ($urandom_range(99) < 60) begin
      v = $urandom;
      v[30:23] = 8'($urandom_range(150, 100));
    end else begin
      do v = $urandom; while (v[30:23] == 8'hFF && v[22:0] != 0);
    end
    return v;
  endfunction

  // Random read of an entry that was written, or an out-of-range index.
  task rand_read();
    logic [11:0] idx;
    longint unsigned cnt;
    int tries;
    cnt = sb.out_count();
    tries = 0;
    do begin
      if (cnt < 4096 && $urandom_range(99) < 20) idx = 12'($urandom_range(4095, cnt));
      else idx = 12'($urandom_range((cnt > 4096) ? 4095 : cnt - 1, 0));
      tries++;
    end while (!sb.readable(idx) && tries < 50);
    if (sb.readable(idx)) send(OP_READ, 32'h0, idx);
  endtask

  task rand_phase();
    longint unsigned n, outs;
    set_shape($urandom_range(7), $urandom_range(6), $urandom_range(6),
              $urandom_range(5), ($urandom_range(9) == 0) ? $urandom_range(8191) :
              $urandom_range(4), $urandom_range(15));
    n = sb.tensor_size();
    if (n > 80) n = $urandom_range(80, 20);
    else if ($urandom_range(9) == 0) n = n + $urandom_range(n);
    for (longint unsigned i = 0; i < n; i++) begin
      if ($urandom_range(99) < 20) rand_read();
      send(OP_ACCUM, rand_elem(), 12'h0);
    end
    outs = sb.out_count();
    for (longint unsigned i = 0; i < outs && i < 16; i++)
      if (sb.readable(12'(i))) send(OP_READ, 32'h0, 12'(i));
    rand_read();
  endtask

  initial begin
    logic [31:0] extremes [8];
    extremes = '{32'h0000_0000, 32'h8000_0000, 32'h7F7F_FFFF, 32'h0000_0001,
                 32'h3F80_0000, 32'hFF80_0000, 32'h807F_FFFF, 32'hFF7F_FFFF};
    sb = new();
    sent = 0;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_ACCUM;
    cfg_we    = 1'b0;
    cfg_index = CFG_RANK;
    cfg_data  = '0;
    tx_idle_pct = 17;
    rx_idle_pct = 69;
    rx_hold = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // Reset shape: a single element, then one good and one bad read.
    send(OP_ACCUM, 32'h4040_0000, 12'h0);
    send(OP_READ, 32'h0, 12'h0);
    send(OP_READ, 32'h0, 12'hFFF);
    drain();

    // All axes reduced: extremes, overflow to infinity, underflow to zero.
    set_shape(1, 8, 1, 1, 1, 1);
    foreach (extremes[i]) send(OP_ACCUM, extremes[i], 12'h0);
    send(OP_READ, 32'h0, 12'h0);
    send(OP_READ, 32'h0, 12'h1);
    drain();

    // Nothing reduced, rank zero acting as one, oversized extent.
    set_shape(0, 8191, 0, 8191, 8191, 14);
    foreach (extremes[i]) send(OP_ACCUM, extremes[i] ^ 32'h0000_0003, 12'h0);
    for (int i = 0; i < 8; i++) send(OP_READ, 32'h0, 12'(i));
    drain();

    // Long receiver hold-off while reads keep coming.
    set_shape(7, 2, 3, 2, 2, 5);
    for (int i = 0; i < 24; i++) send(OP_ACCUM, rand_elem(), 12'h0);
    rx_hold = 300;
    for (int i = 0; i < 12; i++) send(OP_READ, 32'h0, 12'($urandom_range(5)));
    drain();

    while (sent < 1350) begin
      if (sent > 900) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end else if (sent > 450) begin
        tx_idle_pct = 69;
        rx_idle_pct = 17;
      end
      rand_phase();
      drain();
    end

    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

// ----- tensor_reduce_sum_square_core.f -----
sv/trss_pkg.sv
sv/trss_ram.sv
sv/trss_fpu.sv
sv/tensor_reduce_sum_square_core.sv
test/testbench.sv
